// ===== rtl/mstod_pkg.sv =====
`timescale 1ns / 1ps

package mstod_pkg;

  // Field widths
  localparam int unsigned SampleW  = 32;
  localparam int unsigned MsW      = 10;
  localparam int unsigned SecW     = 6;
  localparam int unsigned MinW     = 6;
  localparam int unsigned TodHourW = 5;
  localparam int unsigned HourQW   = 11;  // whole hours in one 32-bit delta: at most 1193
  localparam int unsigned StepCntW = 2;
  localparam int unsigned RecipW   = 28;  // widest reciprocal, floor(2^32 / 24)

  // Radix constants
  localparam logic [MsW-1:0] MsPerSec   = 10'd1000;
  localparam logic [MsW-1:0] SecPerMin  = 10'd60;
  localparam logic [MsW-1:0] MinPerHour = 10'd60;
  localparam logic [MsW-1:0] HoursPerDay = 10'd24;

  // Divider steps per digit: multiply, then remainder
  localparam logic [StepCntW-1:0] DivSteps = 2'd2;

  // Divider phases: delta is split into ms, sec, min and hour digits
  typedef enum logic [1:0] {
    PH_MS   = 2'd0,
    PH_SEC  = 2'd1,
    PH_MIN  = 2'd2,
    PH_HOUR = 2'd3
  } phase_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic   load_in;
    logic   eval;
    logic   div_load;
    phase_t load_phase;
    logic   div_step;
    logic   save;
    phase_t save_phase;
    logic   apply;
    logic   out_load;
  } mstod_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic adv;
  } mstod_stat_t;

  // Divisor used in each phase
  function automatic logic [MsW-1:0] phase_divisor(phase_t p);
    logic [MsW-1:0] d;
    case (p)
      PH_MS:   d = MsPerSec;
      PH_SEC:  d = SecPerMin;
      PH_MIN:  d = MinPerHour;
      PH_HOUR: d = HoursPerDay;
      default: d = MsPerSec;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor) for each phase
  function automatic logic [RecipW-1:0] phase_recip(phase_t p);
    logic [RecipW-1:0] r;
    case (p)
      PH_MS:   r = 28'd4294967;
      PH_SEC:  r = 28'd71582788;
      PH_MIN:  r = 28'd71582788;
      PH_HOUR: r = 28'd178956970;
      default: r = 28'd4294967;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ms_tick_time_of_day_clock.sv =====
`timescale 1ns / 1ps

// Time-of-day and runtime clock fed by samples of a free-running 32-bit
// millisecond counter.
// Input channel (in_valid/in_ready, in_ms_sample): one counter sample per
// transaction. A sample above the last advancing one advances both clocks by
// the difference; any other sample counts as a stall.
// Result channel (out_valid/out_ready): one transaction per input with both
// clocks, the last advancing sample and a status bit that is set when the
// stall count reaches cfg stall limit (the count then restarts).
// cfg_we/cfg_wdata write the stall limit; write it only while idle.
// The shared reciprocal divider splits the delta of an advancing sample
// into ms, sec, min and hour digits (per digit: multiply, remainder,
// fix-up). A stall sample skips the divider. in_ready is high again in
// the cycle after the result is loaded, so the block takes no new sample
// until the result of the last one is loaded.
// The result sits in an output register: while the receiver stalls, the
// next sample is still accepted and processed, and waits at the end until
// the register frees up.
// Reset clears both clocks, the last sample and the stall count, and sets
// the stall limit to all ones.
module ms_tick_time_of_day_clock
  import mstod_pkg::*;
#(
  parameter int unsigned RUN_HOUR_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [SampleW-1:0]       in_ms_sample,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [MsW-1:0]           out_tod_millis,
  output logic [SecW-1:0]          out_tod_seconds,
  output logic [MinW-1:0]          out_tod_minutes,
  output logic [TodHourW-1:0]      out_tod_hours,
  output logic [MsW-1:0]           out_run_millis,
  output logic [SecW-1:0]          out_run_seconds,
  output logic [MinW-1:0]          out_run_minutes,
  output logic [RUN_HOUR_BITS-1:0] out_run_hours,
  output logic [SampleW-1:0]       out_total_millis,
  output logic                     out_status,
  input  logic                     cfg_we,
  input  logic [SampleW-1:0]       cfg_wdata
);

  mstod_cmd_t  cmd;
  mstod_stat_t stat;

  mstod_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mstod_dp #(
    .RUN_HOUR_BITS (RUN_HOUR_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_ms_sample     (in_ms_sample),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_tod_millis   (out_tod_millis),
    .out_tod_seconds  (out_tod_seconds),
    .out_tod_minutes  (out_tod_minutes),
    .out_tod_hours    (out_tod_hours),
    .out_run_millis   (out_run_millis),
    .out_run_seconds  (out_run_seconds),
    .out_run_minutes  (out_run_minutes),
    .out_run_hours    (out_run_hours),
    .out_total_millis (out_total_millis),
    .out_status       (out_status)
  );

endmodule

// ===== rtl/mstod_ctrl.sv =====
`timescale 1ns / 1ps

module mstod_ctrl
  import mstod_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mstod_stat_t stat,
  output mstod_cmd_t  cmd
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EVAL  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_APPLY = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  phase_t                phase_r, phase_nxt;
  logic [StepCntW-1:0]   cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  phase_t                next_phase;

  assign next_phase = phase_t'(2'(phase_r) + 2'd1);
  assign in_ready   = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    cmd            = '0;
    cmd.save_phase = phase_r;
    cmd.load_phase = next_phase;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.adv) begin
          cmd.div_load   = 1'b1;
          cmd.load_phase = PH_MS;
          phase_nxt      = PH_MS;
          cnt_nxt        = '0;
          state_nxt      = ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV: begin
        if (cnt_r != DivSteps) begin
          cmd.div_step = 1'b1;
          cnt_nxt      = cnt_r + 1'b1;
        end else begin
          cmd.save = 1'b1;
          if (phase_r == PH_HOUR) begin
            state_nxt = ST_APPLY;
          end else begin
            cmd.div_load = 1'b1;
            phase_nxt    = next_phase;
            cnt_nxt      = '0;
          end
        end
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_MS;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // A pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register loaded while previous result pending");

  // Step counter never runs past the phase length
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DivSteps))
    else $error("divider step count out of range");

  // An accepted transaction is evaluated in the next cycle
  a_accept_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_EVAL))
    else $error("accepted transaction not evaluated");

endmodule

// ===== rtl/mstod_dp.sv =====
`timescale 1ns / 1ps

module mstod_dp
  import mstod_pkg::*;
#(
  parameter int unsigned RUN_HOUR_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mstod_cmd_t               cmd,
  output mstod_stat_t              stat,
  input  logic [SampleW-1:0]       in_ms_sample,
  input  logic                     cfg_we,
  input  logic [SampleW-1:0]       cfg_wdata,
  output logic [MsW-1:0]           out_tod_millis,
  output logic [SecW-1:0]          out_tod_seconds,
  output logic [MinW-1:0]          out_tod_minutes,
  output logic [TodHourW-1:0]      out_tod_hours,
  output logic [MsW-1:0]           out_run_millis,
  output logic [SecW-1:0]          out_run_seconds,
  output logic [MinW-1:0]          out_run_minutes,
  output logic [RUN_HOUR_BITS-1:0] out_run_hours,
  output logic [SampleW-1:0]       out_total_millis,
  output logic                     out_status
);

  localparam int unsigned HourSumW =
    ((RUN_HOUR_BITS > HourQW) ? RUN_HOUR_BITS : HourQW) + 1;

  // Adds two digits plus carry-in and wraps at the modulus; returns {carry, digit}
  function automatic logic [MsW:0] digit_add(logic [MsW-1:0] a, logic [MsW-1:0] b,
                                             logic cin, logic [MsW-1:0] modulus);
    logic [MsW:0] s;
    logic         c;
    s = {1'b0, a} + {1'b0, b} + {{MsW{1'b0}}, cin};
    c = (s >= {1'b0, modulus});
    if (c) begin
      s = s - {1'b0, modulus};
    end
    return {c, s[MsW-1:0]};
  endfunction

  // Architectural state
  logic [SampleW-1:0]       sample_r;
  logic [SampleW-1:0]       last_r, last_nxt;
  logic [SampleW-1:0]       stall_cnt_r, stall_cnt_nxt;
  logic [SampleW-1:0]       stall_limit_r;
  logic                     stat_r, stat_nxt;
  logic [MsW-1:0]           tod_ms_r, run_ms_r;
  logic [SecW-1:0]          tod_sec_r, run_sec_r;
  logic [MinW-1:0]          tod_min_r, run_min_r;
  logic [TodHourW-1:0]      tod_hour_r;
  logic [RUN_HOUR_BITS-1:0] run_hour_r;

  // Divider and delta digits
  logic [SampleW-1:0]       dvd_r;
  logic [SampleW-1:0]       quo_r;
  logic [MsW:0]             rem_r;
  logic [MsW-1:0]           div_r;
  logic [RecipW-1:0]        recip_r;
  logic [MsW-1:0]           d_ms_r, d_sec_r, d_min_r, d_hr24_r;
  logic [HourQW-1:0]        d_hq_r;

  logic [SampleW-1:0]       stall_inc;
  logic [SampleW-1:0]       load_src;
  logic [SampleW+RecipW-1:0] prod;
  logic [MsW:0]             qd_lo;
  logic                     ge_fix;
  logic [MsW-1:0]           rem_fix;
  logic [SampleW-1:0]       quo_fix;

  logic [MsW:0]             tod_ms_a, tod_sec_a, tod_min_a, tod_hr_a;
  logic [MsW:0]             run_ms_a, run_sec_a, run_min_a;
  logic [HourSumW-1:0]      run_hr_sum;

  assign stat.adv  = (sample_r > last_r);
  assign stall_inc = stall_cnt_r + 1'b1;

  // Evaluation: advance or count a stall
  always_comb begin
    last_nxt      = last_r;
    stall_cnt_nxt = stall_cnt_r;
    stat_nxt      = stat_r;
    if (cmd.eval) begin
      if (stat.adv) begin
        last_nxt      = sample_r;
        stall_cnt_nxt = '0;
        stat_nxt      = 1'b0;
      end else if (stall_inc == stall_limit_r) begin
        stall_cnt_nxt = '0;
        stat_nxt      = 1'b1;
      end else begin
        stall_cnt_nxt = stall_inc;
        stat_nxt      = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r        <= '0;
      stall_cnt_r   <= '0;
      stall_limit_r <= '1;
      stat_r        <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      stall_cnt_r <= stall_cnt_nxt;
      stat_r      <= stat_nxt;
      if (cfg_we) begin
        stall_limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_r <= in_ms_sample;
    end
  end

  // Reciprocal divider by a small constant: the multiply estimate is at
  // most one short, so the remainder lies below twice the divisor and
  // one compare and subtract settles both quotient and remainder
  assign load_src = (cmd.load_phase == PH_MS) ? (sample_r - last_r) : quo_fix;
  assign prod     = dvd_r * recip_r;
  assign qd_lo    = (MsW+1)'(quo_r[MsW:0] * div_r);
  assign ge_fix   = (rem_r >= {1'b0, div_r});
  assign rem_fix  = ge_fix ? MsW'(rem_r - {1'b0, div_r}) : rem_r[MsW-1:0];
  assign quo_fix  = quo_r + SampleW'(ge_fix);

  // First step forms the estimate, second step its remainder
  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      dvd_r   <= load_src;
      div_r   <= phase_divisor(cmd.load_phase);
      recip_r <= phase_recip(cmd.load_phase);
    end else if (cmd.div_step) begin
      quo_r <= SampleW'(prod[SampleW+RecipW-1:SampleW]);
      rem_r <= dvd_r[MsW:0] - qd_lo;
    end
  end

  // Capture each digit of the delta; quo_fix holds the quotient here
  always_ff @(posedge clk) begin
    if (cmd.save) begin
      case (cmd.save_phase)
        PH_MS:   d_ms_r <= rem_fix;
        PH_SEC:  d_sec_r <= rem_fix;
        PH_MIN: begin
          d_min_r <= rem_fix;
          d_hq_r  <= quo_fix[HourQW-1:0];
        end
        PH_HOUR: d_hr24_r <= rem_fix;
        default: d_ms_r <= rem_fix;
      endcase
    end
  end

  // Digit-wise add with carries into both clocks
  assign tod_ms_a  = digit_add(tod_ms_r, d_ms_r, 1'b0, MsPerSec);
  assign tod_sec_a = digit_add(MsW'(tod_sec_r), d_sec_r, tod_ms_a[MsW], SecPerMin);
  assign tod_min_a = digit_add(MsW'(tod_min_r), d_min_r, tod_sec_a[MsW], MinPerHour);
  assign tod_hr_a  = digit_add(MsW'(tod_hour_r), d_hr24_r, tod_min_a[MsW], HoursPerDay);

  assign run_ms_a  = digit_add(run_ms_r, d_ms_r, 1'b0, MsPerSec);
  assign run_sec_a = digit_add(MsW'(run_sec_r), d_sec_r, run_ms_a[MsW], SecPerMin);
  assign run_min_a = digit_add(MsW'(run_min_r), d_min_r, run_sec_a[MsW], MinPerHour);
  assign run_hr_sum = HourSumW'(run_hour_r) + HourSumW'(d_hq_r)
                    + HourSumW'(run_min_a[MsW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tod_ms_r   <= '0;
      tod_sec_r  <= '0;
      tod_min_r  <= '0;
      tod_hour_r <= '0;
      run_ms_r   <= '0;
      run_sec_r  <= '0;
      run_min_r  <= '0;
      run_hour_r <= '0;
    end else if (cmd.apply) begin
      tod_ms_r   <= tod_ms_a[MsW-1:0];
      tod_sec_r  <= tod_sec_a[SecW-1:0];
      tod_min_r  <= tod_min_a[MinW-1:0];
      tod_hour_r <= tod_hr_a[TodHourW-1:0];
      run_ms_r   <= run_ms_a[MsW-1:0];
      run_sec_r  <= run_sec_a[SecW-1:0];
      run_min_r  <= run_min_a[MinW-1:0];
      run_hour_r <= run_hr_sum[RUN_HOUR_BITS-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_tod_millis   <= tod_ms_r;
      out_tod_seconds  <= tod_sec_r;
      out_tod_minutes  <= tod_min_r;
      out_tod_hours    <= tod_hour_r;
      out_run_millis   <= run_ms_r;
      out_run_seconds  <= run_sec_r;
      out_run_minutes  <= run_min_r;
      out_run_hours    <= run_hour_r;
      out_total_millis <= last_r;
      out_status       <= stat_r;
    end
  end

  // Time-of-day digits stay normalized after every update
  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.apply |=> ((tod_ms_r < MsPerSec) && (tod_sec_r < 6'd60)
                   && (tod_min_r < 6'd60) && (tod_hour_r < 5'd24)))
    else $error("time-of-day clock not normalized");

endmodule

// ===== tb/sv/tb_ms_tick_time_of_day_clock.sv =====
`timescale 1ns / 1ps

module tb_ms_tick_time_of_day_clock;
  import mstod_pkg::*;

  localparam int unsigned RunHourW = 16;
  localparam longint unsigned RunHourMask = (64'd1 << RunHourW) - 64'd1;

  // Clock digits; hour is kept wide and wrapped by the caller
  typedef struct {
    logic [MsW-1:0]  ms;
    logic [SecW-1:0] sec;
    logic [MinW-1:0] mins;
    longint unsigned hour;
  } dial_t;

  // One result transaction as the block should present it
  typedef struct {
    logic [MsW-1:0]      tod_ms;
    logic [SecW-1:0]     tod_sec;
    logic [MinW-1:0]     tod_min;
    logic [TodHourW-1:0] tod_hr;
    logic [MsW-1:0]      run_ms;
    logic [SecW-1:0]     run_sec;
    logic [MinW-1:0]     run_min;
    logic [RunHourW-1:0] run_hr;
    logic [SampleW-1:0]  total;
    logic                status;
  } clock_reading_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [SampleW-1:0]   in_ms_sample = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [MsW-1:0]       out_tod_millis;
  logic [SecW-1:0]      out_tod_seconds;
  logic [MinW-1:0]      out_tod_minutes;
  logic [TodHourW-1:0]  out_tod_hours;
  logic [MsW-1:0]       out_run_millis;
  logic [SecW-1:0]      out_run_seconds;
  logic [MinW-1:0]      out_run_minutes;
  logic [RunHourW-1:0]  out_run_hours;
  logic [SampleW-1:0]   out_total_millis;
  logic                 out_status;
  logic                 cfg_we = 1'b0;
  logic [SampleW-1:0]   cfg_wdata = '0;

  // Stimulus and result bookkeeping
  logic [SampleW-1:0]   samples_pending[$];
  clock_reading_t       readings_due[$];
  logic [SampleW-1:0]   ms_hw = '0;      // highest sample queued so far
  int                   mismatches = 0;
  int                   sent_cnt = 0;
  int                   in_gap = 0;
  int                   out_wait = 0;
  bit                   idle_on = 1'b1;
  bit                   in_taken = 1'b0;
  bit                   out_taken = 1'b0;

  // Predictor state
  dial_t                tod_dial = '{default: 0};
  dial_t                run_dial = '{default: 0};
  logic [SampleW-1:0]   last_ms = '0;
  logic [SampleW-1:0]   stalls_seen = '0;
  logic [SampleW-1:0]   stall_limit_m = '1;

  ms_tick_time_of_day_clock #(
    .RUN_HOUR_BITS(RunHourW)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_ms_sample     (in_ms_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_tod_millis   (out_tod_millis),
    .out_tod_seconds  (out_tod_seconds),
    .out_tod_minutes  (out_tod_minutes),
    .out_tod_hours    (out_tod_hours),
    .out_run_millis   (out_run_millis),
    .out_run_seconds  (out_run_seconds),
    .out_run_minutes  (out_run_minutes),
    .out_run_hours    (out_run_hours),
    .out_total_millis (out_total_millis),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Add delta ms to a clock, carrying at 1000 ms, 60 s and 60 min
  function automatic dial_t dial_add(dial_t d, longint unsigned delta);
    longint unsigned t;
    t = d.ms + delta;
    d.ms = MsW'(t % 1000);
    t = d.sec + t / 1000;
    d.sec = SecW'(t % 60);
    t = d.mins + t / 60;
    d.mins = MinW'(t % 60);
    d.hour = d.hour + t / 60;
    return d;
  endfunction

  // Advance both clocks or count a stall, then form the result
  task automatic predict_reading(input logic [SampleW-1:0] s, output clock_reading_t r);
    longint unsigned delta;
    r.status = 1'b0;
    if (s > last_ms) begin
      delta = 64'(s) - 64'(last_ms);
      stalls_seen = '0;
      last_ms = s;
      tod_dial = dial_add(tod_dial, delta);
      tod_dial.hour = tod_dial.hour % 24;
      run_dial = dial_add(run_dial, delta);
      run_dial.hour = run_dial.hour & RunHourMask;
    end else begin
      // 32-bit count, wraps like the hardware
      stalls_seen = stalls_seen + 1'b1;
      if (stalls_seen == stall_limit_m) begin
        r.status = 1'b1;
        stalls_seen = '0;
      end
    end
    r.tod_ms  = tod_dial.ms;
    r.tod_sec = tod_dial.sec;
    r.tod_min = tod_dial.mins;
    r.tod_hr  = TodHourW'(tod_dial.hour);
    r.run_ms  = run_dial.ms;
    r.run_sec = run_dial.sec;
    r.run_min = run_dial.mins;
    r.run_hr  = RunHourW'(run_dial.hour);
    r.total   = last_ms;
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
    end
  endtask

  // Input transaction accepted: predict its result
  always @(posedge clk) begin : in_accept
    clock_reading_t r;
    if (rst_n && in_valid && in_ready) begin
      predict_reading(in_ms_sample, r);
      readings_due.push_back(r);
      in_taken = 1'b1;
    end
  end

  // Result transaction accepted: compare with the oldest prediction
  always @(posedge clk) begin : out_check
    clock_reading_t r;
    if (rst_n && out_valid && out_ready) begin
      out_taken = 1'b1;
      if (readings_due.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, total_millis actual %0d",
                 $time, out_total_millis);
      end else begin
        r = readings_due.pop_front();
        check_field("tod_millis", r.tod_ms, out_tod_millis);
        check_field("tod_seconds", r.tod_sec, out_tod_seconds);
        check_field("tod_minutes", r.tod_min, out_tod_minutes);
        check_field("tod_hours", r.tod_hr, out_tod_hours);
        check_field("run_millis", r.run_ms, out_run_millis);
        check_field("run_seconds", r.run_sec, out_run_seconds);
        check_field("run_minutes", r.run_min, out_run_minutes);
        check_field("run_hours", r.run_hr, out_run_hours);
        check_field("total_millis", r.total, out_total_millis);
        check_field("status", r.status, out_status);
      end
    end
  end

  // Sample driver: one valid update per falling edge
  always @(negedge clk) begin : drive_samples
    logic next_valid;
    next_valid = in_valid;
    if (in_valid && in_taken) begin
      next_valid = 1'b0;
      in_taken = 1'b0;
    end
    if (!next_valid) begin
      if (in_gap != 0) begin
        in_gap--;
      end else if (samples_pending.size() != 0) begin
        in_ms_sample <= samples_pending.pop_front();
        next_valid = 1'b1;
        sent_cnt++;
        // quiet stretch every so often
        idle_on = (sent_cnt % 120) < 90;
        in_gap = idle_on ? $urandom_range(3, 0) : 0;
      end
    end
    in_valid <= next_valid;
  end

  // Result receiver: holds ready low for a drawn number of cycles per result
  always @(negedge clk) begin : drive_ready
    if (out_taken) begin
      out_taken = 1'b0;
      out_wait = idle_on ? $urandom_range(3, 0) : 0;
    end
    if (out_wait != 0) begin
      out_ready <= 1'b0;
      out_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Block until every queued sample has its result back
  task automatic wait_drained();
    @(posedge clk);
    while (samples_pending.size() != 0 || in_valid || readings_due.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_stall_limit(input logic [SampleW-1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    stall_limit_m = v;
  endtask

  task automatic push_sample(input logic [SampleW-1:0] s);
    samples_pending.push_back(s);
    if (s > ms_hw) begin
      ms_hw = s;
    end
  endtask

  // Mix of equal, backward and forward samples of several step sizes
  task automatic push_random(input int n);
    int kind;
    logic [SampleW-1:0] s;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99, 0);
      if (kind < 8) begin
        s = ms_hw;
      end else if (kind < 25) begin
        s = $urandom_range(ms_hw, 0);
      end else if (kind < 70) begin
        s = ms_hw + $urandom_range(1500, 1);
      end else if (kind < 92) begin
        s = ms_hw + $urandom_range(250000, 1);
      end else begin
        s = ms_hw + $urandom_range(32'h0100_0000, 1);
      end
      push_sample(s);
    end
  endtask

  initial begin : stimulus
    logic [SampleW-1:0] first_steps[14];
    first_steps = '{32'd0, 32'd0, 32'd500, 32'd500, 32'd499, 32'd999, 32'd1000,
                    32'd1001, 32'd60000, 32'd3599999, 32'd3600000, 32'd86399999,
                    32'd90000000, 32'd176400123};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset limit: zero first sample stalls, small first sample kept whole,
    // carries through seconds, minutes, hours and the day wrap
    foreach (first_steps[i]) begin
      push_sample(first_steps[i]);
    end

    // Every stall flags
    write_stall_limit(32'd1);
    push_sample(32'd176400123);
    push_sample(32'd5);
    push_sample(32'd176400124);

    // Two stalls, then the limit drops below the count: no flag until wrap
    write_stall_limit(32'd3);
    push_sample(32'd176400124);
    push_sample(32'd100);
    write_stall_limit(32'd1);
    push_sample(32'd7);
    push_sample(32'd176400124);
    push_sample(32'd176400200);

    // Random phases across several limits
    write_stall_limit($urandom_range(8, 1));
    push_random(90);
    write_stall_limit(32'd0);
    push_random(90);
    write_stall_limit(32'hFFFF_FFFF);
    push_random(90);
    write_stall_limit($urandom_range(40, 2));
    push_random(90);

    // Counter at its top, then wrapped and arbitrary values, which all stall
    write_stall_limit(32'd2);
    push_sample(32'hFFFF_FFFF);
    push_sample(32'd0);
    for (int i = 0; i < 25; i++) begin
      push_sample($urandom());
    end

    wait_drained();
    repeat (60) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Run limit
  initial begin : watchdog
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
